// File: rtl/cai_pkg.sv
package cai_pkg;

	// Default sizes of the run counters and reference positions
	localparam int COUNT_BITS_DEF = 32;
	localparam int REF_BITS_DEF   = 41;

	// Fixed field widths
	localparam int BYTE_BITS = 8;
	localparam int CFG_BITS  = 16;

	// Threshold after reset
	localparam logic [CFG_BITS-1:0] MIN_MATCH_RST = 16'd20;

	// Decimal digit range
	localparam logic [BYTE_BITS-1:0] CH_0 = 8'h30;
	localparam logic [BYTE_BITS-1:0] CH_9 = 8'h39;

	// Operation letters: match class
	localparam logic [BYTE_BITS-1:0] OP_M  = 8'h4D;
	localparam logic [BYTE_BITS-1:0] OP_EQ = 8'h3D;
	localparam logic [BYTE_BITS-1:0] OP_X  = 8'h58;
	// Query-only class
	localparam logic [BYTE_BITS-1:0] OP_I  = 8'h49;
	localparam logic [BYTE_BITS-1:0] OP_S  = 8'h53;
	localparam logic [BYTE_BITS-1:0] OP_H  = 8'h48;
	// Reference-only class
	localparam logic [BYTE_BITS-1:0] OP_D  = 8'h44;
	localparam logic [BYTE_BITS-1:0] OP_N  = 8'h4E;
	localparam logic [BYTE_BITS-1:0] OP_P  = 8'h50;

endpackage

// File: rtl/cigar_anchored_interval.sv
// Streaming CIGAR span finder.
// Input channel (in_valid/in_ready): one CIGAR character per transfer in
// text_byte, with ref_start sampled on the first character of each string
// and last marking its final character. Digits build a run length, a letter
// closes the run. The first match run at least min_match_len long is the
// anchor; later runs commit only when a long match follows them.
// Output channel (out_valid/out_ready): one transfer per string, after the
// character with last set, giving the query and reference span.
// Config channel (cfg_valid/cfg_ready): writes min_match_len; always ready;
// the user must write it only while no string is in flight, which the block
// does not enforce. Throughput: one character per cycle while no last
// character waits on a held result. The last character sits in the input
// register and loads the result register through the saturating-add update
// between them; that load also raises out_valid.
// A stalled receiver holds the result; ordinary characters still flow, and
// only a further last character waits until the held result is taken.
// Reset (arst_n low) empties both registers, clears all per-string state
// and sets min_match_len to 20.
module cigar_anchored_interval #(
	parameter int COUNT_BITS = cai_pkg::COUNT_BITS_DEF,
	parameter int REF_BITS   = cai_pkg::REF_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cai_pkg::CFG_BITS-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cai_pkg::BYTE_BITS-1:0]     text_byte,
	input  logic [REF_BITS-2:0]               ref_start,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COUNT_BITS-1:0]             query_first,
	output logic signed [COUNT_BITS:0]        query_final,
	output logic signed [REF_BITS-1:0]        ref_first,
	output logic signed [REF_BITS-1:0]        ref_final,
	output logic                              anchor_found
);
	import cai_pkg::*;

	localparam int ADD_BITS = (REF_BITS > COUNT_BITS) ? REF_BITS : COUNT_BITS;
	localparam int SUM_BITS = ADD_BITS + 2;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic signed [REF_BITS-1:0] REF_MAX = {1'b0, {(REF_BITS-1){1'b1}}};

	typedef enum logic [1:0] {PH_SEEK, PH_EXTEND} phase_t;

	// Saturating count add
	function automatic logic [COUNT_BITS-1:0] qadd(input logic [COUNT_BITS-1:0] a,
			input logic [COUNT_BITS-1:0] b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, CNT_MAX}) ? CNT_MAX : s[COUNT_BITS-1:0];
	endfunction

	// Saturating reference add, a in [-1, REF_MAX], b non-negative
	function automatic logic signed [REF_BITS-1:0] radd(input logic signed [REF_BITS-1:0] a,
			input logic [ADD_BITS-1:0] b);
		logic signed [SUM_BITS-1:0] s;
		s = SUM_BITS'(a) + $signed(SUM_BITS'(b));
		return (s >= SUM_BITS'(REF_MAX)) ? REF_MAX : $signed(s[REF_BITS-1:0]);
	endfunction

	// Input register
	logic                     v_s1;
	logic [BYTE_BITS-1:0]     text_s1;
	logic [REF_BITS-2:0]      start_s1;
	logic                     last_s1;

	// Per-string state
	phase_t                   phase_q;
	logic                     stop_q;
	logic [COUNT_BITS-1:0]    run_q;
	logic                     digits_q;
	logic                     open_q;
	logic [COUNT_BITS-1:0]    qpos_q;
	logic signed [REF_BITS-1:0] rpos_q;
	logic [COUNT_BITS-1:0]    pq_q;
	logic signed [REF_BITS-1:0] pr_q;
	logic [COUNT_BITS-1:0]    aq_q;
	logic signed [REF_BITS-1:0] ar_q;
	logic [CFG_BITS-1:0]      min_q;

	// Result register
	logic                     out_v_q;
	logic                     found_q;
	logic [COUNT_BITS-1:0]    qfirst_q;
	logic [COUNT_BITS-1:0]    qend_q;
	logic signed [REF_BITS-1:0] rfirst_q;
	logic signed [REF_BITS-1:0] rend_q;

	// Next-state values
	phase_t                   n_phase;
	logic                     n_stop;
	logic [COUNT_BITS-1:0]    n_run;
	logic                     n_digits;
	logic [COUNT_BITS-1:0]    n_qpos;
	logic signed [REF_BITS-1:0] n_rpos;
	logic [COUNT_BITS-1:0]    n_pq;
	logic signed [REF_BITS-1:0] n_pr;
	logic [COUNT_BITS-1:0]    n_aq;
	logic signed [REF_BITS-1:0] n_ar;

	logic                     adv;
	logic signed [REF_BITS-1:0] cur_rpos;
	logic                     is_digit;
	logic                     is_match;
	logic                     is_qry;
	logic                     is_ref;
	logic                     is_long;
	logic [3:0]               digit;
	logic [COUNT_BITS+3:0]    run_mul;
	logic [COUNT_BITS-1:0]    pq_len;
	logic signed [REF_BITS-1:0] pr_len;

	// Handshakes: s1 drains unless it holds a last character and the result is stuck
	assign adv       = v_s1 && (!last_s1 || !out_v_q || out_ready);
	assign in_ready  = !v_s1 || adv;
	assign cfg_ready = 1'b1;

	// Character decode
	always_comb begin
		is_digit = (text_s1 >= CH_0) && (text_s1 <= CH_9);
		is_match = (text_s1 == OP_M) || (text_s1 == OP_EQ) || (text_s1 == OP_X);
		is_qry   = (text_s1 == OP_I) || (text_s1 == OP_S) || (text_s1 == OP_H);
		is_ref   = (text_s1 == OP_D) || (text_s1 == OP_N) || (text_s1 == OP_P);
		digit    = 4'(text_s1 - CH_0);
		run_mul  = ({4'b0, run_q} << 3) + ({4'b0, run_q} << 1) + (COUNT_BITS+4)'(digit);
		is_long  = run_q >= COUNT_BITS'(min_q);
	end

	// One character of parsing
	always_comb begin
		cur_rpos = open_q ? rpos_q : $signed({1'b0, start_s1} - 1'b1);
		pq_len   = qadd(pq_q, run_q);
		pr_len   = radd(pr_q, ADD_BITS'(run_q));
		n_phase  = phase_q;
		n_stop   = stop_q;
		n_run    = run_q;
		n_digits = digits_q;
		n_qpos   = qpos_q;
		n_rpos   = cur_rpos;
		n_pq     = pq_q;
		n_pr     = pr_q;
		n_aq     = aq_q;
		n_ar     = ar_q;
		if (!stop_q) begin
			if (is_digit) begin
				n_run    = (run_mul > (COUNT_BITS+4)'(CNT_MAX)) ? CNT_MAX
					: run_mul[COUNT_BITS-1:0];
				n_digits = 1'b1;
			end else if (!digits_q) begin
				n_stop = 1'b1;
			end else begin
				n_run    = '0;
				n_digits = 1'b0;
				if (phase_q == PH_SEEK) begin
					if (is_match) begin
						if (is_long) begin
							n_aq    = qpos_q;
							n_ar    = cur_rpos;
							n_phase = PH_EXTEND;
						end
						n_qpos = qadd(qpos_q, run_q);
						n_rpos = radd(cur_rpos, ADD_BITS'(run_q));
					end else if (is_qry) begin
						n_qpos = qadd(qpos_q, run_q);
					end else if (is_ref) begin
						n_rpos = radd(cur_rpos, ADD_BITS'(run_q));
					end
				end else begin
					// Held runs commit only when a long match closes them
					if (is_match) begin
						n_pq = pq_len;
						n_pr = pr_len;
						if (is_long) begin
							n_qpos = qadd(qpos_q, pq_len);
							n_rpos = radd(cur_rpos, ADD_BITS'($unsigned(pr_len)));
							n_pq   = '0;
							n_pr   = '0;
						end
					end else if (is_qry) begin
						n_pq = pq_len;
					end else if (is_ref) begin
						n_pr = pr_len;
					end
				end
			end
		end
	end

	// Input register control and per-string state; cleared at end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			phase_q  <= PH_SEEK;
			stop_q   <= 1'b0;
			run_q    <= '0;
			digits_q <= 1'b0;
			open_q   <= 1'b0;
			qpos_q   <= '0;
			rpos_q   <= '0;
			pq_q     <= '0;
			pr_q     <= '0;
			aq_q     <= '0;
			ar_q     <= '0;
			min_q    <= MIN_MATCH_RST;
			out_v_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (cfg_valid && cfg_ready) begin
				min_q <= cfg_data;
			end
			if (adv && last_s1) begin
				phase_q  <= PH_SEEK;
				stop_q   <= 1'b0;
				run_q    <= '0;
				digits_q <= 1'b0;
				open_q   <= 1'b0;
				qpos_q   <= '0;
				rpos_q   <= '0;
				pq_q     <= '0;
				pr_q     <= '0;
				aq_q     <= '0;
				ar_q     <= '0;
			end else if (adv) begin
				phase_q  <= n_phase;
				stop_q   <= n_stop;
				run_q    <= n_run;
				digits_q <= n_digits;
				open_q   <= 1'b1;
				qpos_q   <= n_qpos;
				rpos_q   <= n_rpos;
				pq_q     <= n_pq;
				pr_q     <= n_pr;
				aq_q     <= n_aq;
				ar_q     <= n_ar;
			end
			if (adv && last_s1) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ready) begin
			text_s1  <= text_byte;
			start_s1 <= ref_start;
			last_s1  <= last;
		end
		if (adv && last_s1) begin
			found_q  <= (n_phase == PH_EXTEND);
			qfirst_q <= (n_phase == PH_EXTEND) ? n_aq : n_qpos;
			qend_q   <= n_qpos;
			rfirst_q <= (n_phase == PH_EXTEND) ? n_ar : n_rpos;
			rend_q   <= n_rpos;
		end
	end

	// Result fields; the end positions step back one when an anchor exists
	assign out_valid    = out_v_q;
	assign anchor_found = found_q;
	assign query_first  = qfirst_q;
	assign query_final  = $signed({1'b0, qend_q} - (COUNT_BITS+1)'(found_q));
	assign ref_first    = rfirst_q;
	assign ref_final    = $signed(rend_q - REF_BITS'(found_q));

	// Without an anchor the span collapses to one point
	a_no_anchor_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !anchor_found |->
			query_final == $signed({1'b0, query_first}) && ref_final == ref_first)
		else $error("empty span not collapsed");

	// A result appears only after a last character left the input register
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_s1 && last_s1))
		else $error("result without last character");

	// Nothing is held pending before an anchor exists
	a_seek_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEEK |-> pq_q == '0 && pr_q == '0)
		else $error("pending runs while seeking");

	// Committed query position never falls behind the anchor
	a_anchor_order: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_EXTEND |-> aq_q <= qpos_q)
		else $error("anchor beyond query position");

endmodule
